[src/sta_pkg.sv]
// ----------------------------------------------------------------------------
// sta_pkg
// Shared types and constants for the sorted term accumulator: payload
// structs, term record, per-cell flags and the update operation codes.
// ----------------------------------------------------------------------------
package sta_pkg;

  localparam int unsigned MaxTermsDef = 64;
  localparam int unsigned CoefW       = 32;
  localparam int unsigned ExpW        = 16;
  localparam int unsigned StatusW     = 3;
  localparam int unsigned TotalW      = 7;

  typedef enum logic [StatusW-1:0] {
    StatIgnored  = 3'd0,
    StatMerged   = 3'd1,
    StatRemoved  = 3'd2,
    StatInserted = 3'd3,
    StatFullDrop = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OpNone,
    OpMerge,
    OpRemove,
    OpInsert
  } op_e;

  typedef enum logic {
    StIdle,
    StUpdate
  } state_e;

  typedef struct packed {
    logic signed [CoefW-1:0] coefficient;
    logic        [ExpW-1:0]  exponent;
  } in_t;

  typedef struct packed {
    status_e                 status;
    logic        [TotalW-1:0] term_total;
    logic signed [CoefW-1:0] coef_now;
  } out_t;

  typedef struct packed {
    logic [CoefW-1:0] coef;
    logic [ExpW-1:0]  expo;
  } term_t;

  typedef struct packed {
    logic gt;
    logic eq;
    logic zero;
  } flags_t;

endpackage

[src/sorted_term_accumulator.sv]
// ----------------------------------------------------------------------------
// sorted_term_accumulator
// Sparse polynomial held as a chain of cells in descending exponent order; each term is
// merged, removed on a zero sum, inserted in place, dropped if full, or ignored if zero.
// ----------------------------------------------------------------------------
//  channel | signals                          | payload
//  in      | in_valid_i / in_ready_o          | in_data_i  (coefficient, exponent)
//  out     | out_valid_o / out_ready_i        | out_data_o (status, term_total, coef_now)
//
//  for each term, all cells compare in the transfer cycle; then, in the update state, the
//  chain shifts or merges while the result register is loaded.
//  the update waits while the result register still holds an untaken result.
//  reset empties the table (term count zero); cell contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_term_accumulator
  import sta_pkg::*;
#(
  parameter int unsigned MAX_TERMS = MaxTermsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int unsigned CntW = $clog2(MAX_TERMS + 1);

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  in_t             item_q;
  term_t           new_term;
  logic            out_valid_q;
  out_t            out_q, out_d;
  logic            cmp_en, commit;
  op_e             op_sel, op_bcast;
  status_e         status_sel;
  logic            any_hit, any_zero;
  logic [CoefW-1:0] pick_all;

  term_t            term_w  [MAX_TERMS];
  flags_t           flags_w [MAX_TERMS];
  logic [CoefW-1:0] pick_w  [MAX_TERMS];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (in_valid_i) state_d = StUpdate;
      StUpdate: if (!out_valid_q || out_ready_i) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready_o = 1'b0;
    commit     = 1'b0;
    unique case (state_q)
      StIdle:   in_ready_o = 1'b1;
      StUpdate: commit = !out_valid_q || out_ready_i;
      default: begin
        in_ready_o = 1'b0;
        commit     = 1'b0;
      end
    endcase
  end

  assign cmp_en = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmp_en) begin
      item_q <= in_data_i;
    end
  end

  assign new_term.coef = item_q.coefficient;
  assign new_term.expo = item_q.exponent;

  // cell chain
  for (genvar i = 0; i < MAX_TERMS; i++) begin : g_cell
    logic  occ;
    logic  left_gt;
    term_t left_term, right_term;

    assign occ = CntW'(i) < count_q;

    if (i == 0) begin : g_first
      assign left_gt   = 1'b1;
      assign left_term = new_term;
    end else begin : g_mid
      assign left_gt   = flags_w[i-1].gt;
      assign left_term = term_w[i-1];
    end

    if (i == MAX_TERMS - 1) begin : g_last
      assign right_term = term_w[i];
    end else begin : g_inner
      assign right_term = term_w[i+1];
    end

    sta_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .occ_i        (occ),
      .cmp_en_i     (cmp_en),
      .cmp_term_i   (in_data_i),
      .op_i         (op_bcast),
      .new_term_i   (new_term),
      .left_term_i  (left_term),
      .right_term_i (right_term),
      .left_gt_i    (left_gt),
      .term_o       (term_w[i]),
      .flags_o      (flags_w[i]),
      .pick_o       (pick_w[i])
    );
  end

  always_comb begin
    any_hit  = 1'b0;
    any_zero = 1'b0;
    pick_all = '0;
    for (int unsigned k = 0; k < MAX_TERMS; k++) begin
      any_hit  = any_hit | flags_w[k].eq;
      any_zero = any_zero | flags_w[k].zero;
      pick_all = pick_all | pick_w[k];
    end
  end

  // decide the operation from the compare results
  always_comb begin
    op_sel     = OpNone;
    status_sel = StatIgnored;
    count_d    = count_q;
    out_d.coef_now = pick_all;
    if (item_q.coefficient == '0) begin
      op_sel     = OpNone;
      status_sel = StatIgnored;
    end else if (any_hit && any_zero) begin
      op_sel         = OpRemove;
      status_sel     = StatRemoved;
      count_d        = count_q - CntW'(1);
      out_d.coef_now = '0;
    end else if (any_hit) begin
      op_sel     = OpMerge;
      status_sel = StatMerged;
    end else if (count_q == CntW'(MAX_TERMS)) begin
      op_sel         = OpNone;
      status_sel     = StatFullDrop;
      out_d.coef_now = '0;
    end else begin
      op_sel         = OpInsert;
      status_sel     = StatInserted;
      count_d        = count_q + CntW'(1);
      out_d.coef_now = item_q.coefficient;
    end
    out_d.status     = status_sel;
    out_d.term_total = TotalW'(count_d);
  end

  assign op_bcast = commit ? op_sel : OpNone;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (commit) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[src/sta_cell.sv]
// ----------------------------------------------------------------------------
// sta_cell
// One slot of the sorted term chain: holds a term, compares it against the
// incoming term, precomputes the saturated sum and shifts with its neighbors.
// ----------------------------------------------------------------------------
module sta_cell
  import sta_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             occ_i,
  input  logic             cmp_en_i,
  input  in_t              cmp_term_i,
  input  op_e              op_i,
  input  term_t            new_term_i,
  input  term_t            left_term_i,
  input  term_t            right_term_i,
  input  logic             left_gt_i,
  output term_t            term_o,
  output flags_t           flags_o,
  output logic [CoefW-1:0] pick_o
);

  term_t            term_q, term_d;
  flags_t           flags_q, flags_d;
  logic [CoefW-1:0] sum_q, sum_d;
  logic [CoefW:0]   sum_wide;

  // saturating add of held coefficient and incoming coefficient, and compare flags
  always_comb begin
    sum_wide = {term_q.coef[CoefW-1], term_q.coef}
             + {cmp_term_i.coefficient[CoefW-1], cmp_term_i.coefficient};
    if (sum_wide[CoefW] != sum_wide[CoefW-1]) begin
      sum_d = sum_wide[CoefW] ? {1'b1, {(CoefW-1){1'b0}}} : {1'b0, {(CoefW-1){1'b1}}};
    end else begin
      sum_d = sum_wide[CoefW-1:0];
    end
    flags_d.gt   = occ_i && (term_q.expo > cmp_term_i.exponent);
    flags_d.eq   = occ_i && (term_q.expo == cmp_term_i.exponent);
    flags_d.zero = flags_d.eq && (sum_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (cmp_en_i) begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmp_en_i) begin
      sum_q <= sum_d;
    end
  end

  // local update, position taken from own and left neighbor compare flags
  always_comb begin
    term_d = term_q;
    unique case (op_i)
      OpMerge: begin
        if (flags_q.eq) term_d.coef = sum_q;
      end
      OpRemove: begin
        if (!flags_q.gt) term_d = right_term_i;
      end
      OpInsert: begin
        if (!left_gt_i) begin
          term_d = left_term_i;
        end else if (!flags_q.gt) begin
          term_d = new_term_i;
        end
      end
      default: term_d = term_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    term_q <= term_d;
  end

  assign term_o  = term_q;
  assign flags_o = flags_q;
  assign pick_o  = flags_q.eq ? sum_q : '0;

endmodule

[src/sta_checker.sv]
// ----------------------------------------------------------------------------
// sta_checker
// Port-level checks for the sorted term accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module sta_checker
  import sta_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  default disable iff (!rst_ni);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // one term at a time
  a_busy_after_transfer: assert property (@(posedge clk_i)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a term is in update");

  // a new result only comes out of the update cycle
  a_result_from_update: assert property (@(posedge clk_i)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without an update cycle");

  // removed or dropped terms report zero
  a_zero_report: assert property (@(posedge clk_i)
    out_valid_o && (out_data_o.status == StatRemoved || out_data_o.status == StatFullDrop)
    |-> out_data_o.coef_now == '0)
    else $error("nonzero coefficient on removed or dropped term");

  // merged or inserted terms are never zero
  a_nonzero_report: assert property (@(posedge clk_i)
    out_valid_o && (out_data_o.status == StatMerged || out_data_o.status == StatInserted)
    |-> out_data_o.coef_now != '0)
    else $error("zero coefficient on held term");

endmodule

bind sorted_term_accumulator sta_checker u_sta_checker (.*);
